### design/bir_pkg.sv
// Shared types and constants for the bilinear image rotator.
package bir_pkg;

   // Fixed field widths of the request, response and register ports.
   localparam int CFG_W      = 7;
   localparam int ANGLE_W    = 15;
   localparam int COORD_W    = 6;
   localparam int PIX_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_Q13      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_Q13      = 2'd3;

   // Request kinds.
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EMIT = 1'b1;

   // Fixed-point layout of source positions and blend weights.
   localparam int Q13_SHIFT = 13;
   localparam int FRAC_DROP = 5;
   localparam int FRAC_W    = 8;
   localparam int OUT_SHIFT = 16;
   localparam int POS_W     = 25;
   localparam int DIFF_W    = 8;
   localparam int WEIGHT_W  = 9;
   localparam logic [WEIGHT_W-1:0] FRAC_ONE = 9'd256;

   // Shared multiplier operand widths.
   localparam int MUL_A_W = 16;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   typedef struct packed {
      logic                      en;
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_req_type;

endpackage

### design/bir_ram.sv
// Generic memory with one write port and one registered read port.
module bir_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/bir_mul.sv
// Shared signed multiplier with a registered product.
module bir_mul import bir_pkg::*; (
   input  logic                     clock,
   input  mul_req_type              mul_req,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;

   assign prod_in = mul_req.a * mul_req.b;

   // The product holds until the next issued operation.
   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

### design/bilinear_image_rotate_top.sv
// Top level of the bilinear image rotator: sequencer, registers and frame store.
//
// Usage: software sets image_width, image_height, cos_q13 and sin_q13 through the
// csr_ write port while the block is idle, then loads source pixels and requests
// destination pixels on the req_ channel. A load (req_type 0) writes one pixel
// into the frame store in the cycle of its transfer and gives no response; the
// next request may follow in the next cycle. A destination request (req_type 1)
// gives exactly one rsp_pixel_out transfer.
// A request inside the image runs through the states COORD, RANGE, BLEND and
// FINISH, and the block takes no new request until it is back in IDLE. The
// work is set by the single shared 16x18 multiplier: four products for the
// source position, then two per neighbour (weight, then pixel times weight),
// with the frame store read once per neighbour. A request outside the image
// goes straight to FINISH; one whose source position falls outside skips BLEND.
// req_stall is high while a request is being worked on. The response sits in an
// output register, so a stalled response does not block the next transfer of
// the request channel; only a second result finishing behind it waits.
// Synchronous reset returns the sequencer to idle, drops rsp_valid and sets the
// registers to 64, 64, 8192 and 0. The frame store is not cleared.
module bilinear_image_rotate_top import bir_pkg::*; #(
   parameter int MAX_SIDE = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic [COORD_W-1:0]           req_row,
   input  logic [COORD_W-1:0]           req_col,
   input  logic signed [PIX_W-1:0]      req_pixel_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [PIX_W-1:0]      rsp_pixel_out,
   input  logic                         csr_we,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int IDXW   = $clog2(MAX_SIDE);
   localparam int ADDR_W = 2 * IDXW;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam logic [CFG_W-1:0] SIZE_CAP = CFG_W'((MAX_SIDE < 127) ? MAX_SIDE : 127);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COORD,
      ST_RANGE,
      ST_BLEND,
      ST_FINISH
   } state_type;

   // Configuration registers.
   logic [CFG_W-1:0]          width_ff;
   logic [CFG_W-1:0]          height_ff;
   logic signed [ANGLE_W-1:0] cos_ff;
   logic signed [ANGLE_W-1:0] sin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 7'd64;
         height_ff <= 7'd64;
         cos_ff    <= 15'sd8192;
         sin_ff    <= 15'sd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[CFG_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[CFG_W-1:0];
            CSR_COS_Q13:      cos_ff    <= $signed(csr_wdata[ANGLE_W-1:0]);
            CSR_SIN_Q13:      sin_ff    <= $signed(csr_wdata[ANGLE_W-1:0]);
            default: ;
         endcase
      end
   end

   // Sizes clamped to the usable range and the rotation center.
   logic [CFG_W-1:0]   eff_w;
   logic [CFG_W-1:0]   eff_h;
   logic [CFG_W-2:0]   x2;
   logic [CFG_W-2:0]   y2;

   always_comb begin
      if (width_ff == '0) begin
         eff_w = 7'd1;
      end else if (int'(width_ff) > MAX_SIDE) begin
         eff_w = SIZE_CAP;
      end else begin
         eff_w = width_ff;
      end
      if (height_ff == '0) begin
         eff_h = 7'd1;
      end else if (int'(height_ff) > MAX_SIDE) begin
         eff_h = SIZE_CAP;
      end else begin
         eff_h = height_ff;
      end
   end

   assign x2 = eff_w[CFG_W-1:1];
   assign y2 = eff_h[CFG_W-1:1];

   // Sequencer state and datapath registers.
   state_type                  state_ff, state_in;
   logic [2:0]                 step_ff, step_in;
   logic [COORD_W-1:0]         row_ff, row_in;
   logic [COORD_W-1:0]         col_ff, col_in;
   logic signed [POS_W-1:0]    xs_ff, xs_in;
   logic signed [POS_W-1:0]    ys_ff, ys_in;
   logic signed [PROD_W-1:0]   acc_ff, acc_in;
   logic                       zero_ff, zero_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [PIX_W-1:0]    rsp_pixel_ff, rsp_pixel_in;

   logic signed [PROD_W-1:0]   prod;
   logic signed [POS_W-1:0]    prod_pos;
   logic signed [PROD_W-1:0]   blend_sum;
   mul_req_type                mul_req;

   logic signed [DIFF_W-1:0]   dx;
   logic signed [DIFF_W-1:0]   dy;
   logic signed [POS_W-1:0]    xs_lim;
   logic signed [POS_W-1:0]    ys_lim;
   logic                       out_of_range;
   logic [FRAC_W-1:0]          fx;
   logic [FRAC_W-1:0]          fy;
   logic [WEIGHT_W-1:0]        gx;
   logic [WEIGHT_W-1:0]        gy;
   logic [WEIGHT_W-1:0]        wa;
   logic [WEIGHT_W-1:0]        wb;
   logic [IDXW-1:0]            xr;
   logic [IDXW-1:0]            yr;
   logic [IDXW-1:0]            xr1;
   logic [IDXW-1:0]            yr1;

   logic                       load_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic [ADDR_W-1:0]          rd_addr;
   logic [PIX_W-1:0]           rd_data;

   assign dx = $signed({2'b00, col_ff}) - $signed({2'b00, x2});
   assign dy = $signed({2'b00, row_ff}) - $signed({2'b00, y2});

   assign xs_lim = $signed({5'b0, eff_w - 7'd1, 13'b0});
   assign ys_lim = $signed({5'b0, eff_h - 7'd1, 13'b0});
   assign out_of_range = xs_ff[POS_W-1] || (xs_ff >= xs_lim) ||
                         ys_ff[POS_W-1] || (ys_ff >= ys_lim);

   assign fx  = xs_ff[FRAC_DROP +: FRAC_W];
   assign fy  = ys_ff[FRAC_DROP +: FRAC_W];
   assign gx  = FRAC_ONE - {1'b0, fx};
   assign gy  = FRAC_ONE - {1'b0, fy};
   assign xr  = xs_ff[Q13_SHIFT +: IDXW];
   assign yr  = ys_ff[Q13_SHIFT +: IDXW];
   assign xr1 = xr + IDXW'(1);
   assign yr1 = yr + IDXW'(1);

   assign prod_pos  = POS_W'(prod);
   assign blend_sum = acc_ff + prod;

   // Operand selection for the shared multiplier and the neighbour read.
   // Neighbours go in the order: top left, bottom left, top right, bottom right.
   always_comb begin
      mul_req.en = 1'b0;
      mul_req.a  = '0;
      mul_req.b  = '0;
      wa         = '0;
      wb         = '0;
      rd_addr    = {yr, xr};
      case (step_ff[2:1])
         2'd0: begin
            wa      = gx;
            wb      = gy;
            rd_addr = {yr, xr};
         end
         2'd1: begin
            wa      = {1'b0, fy};
            wb      = gx;
            rd_addr = {yr1, xr};
         end
         2'd2: begin
            wa      = gy;
            wb      = {1'b0, fx};
            rd_addr = {yr, xr1};
         end
         default: begin
            wa      = {1'b0, fx};
            wb      = {1'b0, fy};
            rd_addr = {yr1, xr1};
         end
      endcase
      case (state_ff)
         ST_COORD: begin
            mul_req.en = (step_ff < 3'd4);
            case (step_ff)
               3'd0: begin
                  mul_req.a = MUL_A_W'(dx);
                  mul_req.b = MUL_B_W'(cos_ff);
               end
               3'd1: begin
                  mul_req.a = MUL_A_W'(dy);
                  mul_req.b = MUL_B_W'(sin_ff);
               end
               3'd2: begin
                  mul_req.a = MUL_A_W'(dy);
                  mul_req.b = MUL_B_W'(cos_ff);
               end
               default: begin
                  mul_req.a = MUL_A_W'(dx);
                  mul_req.b = MUL_B_W'(sin_ff);
               end
            endcase
         end
         ST_BLEND: begin
            mul_req.en = 1'b1;
            if (!step_ff[0]) begin
               mul_req.a = $signed({7'b0, wa});
               mul_req.b = $signed({9'b0, wb});
            end else begin
               // The weight from the previous step is still in the product register.
               mul_req.a = $signed(rd_data);
               mul_req.b = prod[MUL_B_W-1:0];
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      xs_in        = xs_ff;
      ys_in        = ys_ff;
      acc_in       = acc_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_type == REQ_EMIT)) begin
               row_in  = req_row;
               col_in  = req_col;
               step_in = '0;
               xs_in   = $signed({6'b0, x2, 13'b0});
               ys_in   = $signed({6'b0, y2, 13'b0});
               acc_in  = '0;
               if (({1'b0, req_row} >= eff_h) || ({1'b0, req_col} >= eff_w)) begin
                  zero_in  = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  zero_in  = 1'b0;
                  state_in = ST_COORD;
               end
            end
         end
         ST_COORD: begin
            // Each product is added in the cycle after it was issued.
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd1, 3'd2: xs_in = xs_ff + prod_pos;
               3'd3:       ys_in = ys_ff + prod_pos;
               3'd4:       ys_in = ys_ff - prod_pos;
               default: ;
            endcase
            if (step_ff == 3'd4) begin
               step_in  = '0;
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            step_in = '0;
            if (out_of_range) begin
               zero_in  = 1'b1;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            step_in = step_ff + 3'd1;
            if (!step_ff[0] && (step_ff != 3'd0)) begin
               acc_in = blend_sum;
            end
            if (step_ff == 3'd7) begin
               step_in  = '0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // The last weighted pixel is folded in here, then floor-shifted.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = zero_ff ? '0 : blend_sum[OUT_SHIFT +: PIX_W];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff       <= row_in;
      col_ff       <= col_in;
      xs_ff        <= xs_in;
      ys_ff        <= ys_in;
      acc_ff       <= acc_in;
      zero_ff      <= zero_in;
      rsp_pixel_ff <= rsp_pixel_in;
   end

   // Loads outside the store are dropped.
   assign load_en = req_valid && !req_stall && (req_type == REQ_LOAD) &&
                    (int'(req_row) < MAX_SIDE) && (int'(req_col) < MAX_SIDE);
   assign wr_addr = {IDXW'(req_row), IDXW'(req_col)};

   bir_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (wr_addr),
      .wr_data (req_pixel_in),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bir_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;

endmodule

### design/bir_checker.sv
// Port-level checks for the bilinear image rotator and their binding.
module bir_checker import bir_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    req_type,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [PIX_W-1:0] rsp_pixel_out
);

   logic req_xfer;

   assign req_xfer = req_valid && !req_stall;

   // After reset the block is idle and holds no response.
   assert property (@(posedge clock) reset |=> !req_stall && !rsp_valid)
      else $error("block not idle after reset");

   // A load transfer completes in its own cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_type == REQ_LOAD)) |=> !req_stall)
      else $error("load transfer left the block busy");

   // A destination request leaves the block busy in the cycle after its transfer.
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_type == REQ_EMIT)) |=> req_stall)
      else $error("request transfer did not start work");

   // A new response only appears when a request was being worked on.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a pending request");

   // A stalled response holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_pixel_out)))
      else $error("stalled response changed");

endmodule

bind bilinear_image_rotate_top bir_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_type      (req_type),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_pixel_out (rsp_pixel_out)
);
